>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the top-K score selector. Each macro
// expects clk and rst_n in scope and reports through $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define TKSS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TKSS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define TKSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tkss_pkg.sv
// ---------------------------------------------------------------------------
// tkss_pkg
// Transaction types and fixed field widths of the top-K score selector.
// ---------------------------------------------------------------------------
`default_nettype none

package tkss_pkg;

    localparam int SCORE_W = 32;
    localparam int RANK_W  = 3;
    localparam int INDEX_W = 10;

    // One incoming score transaction.
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      last_score;
    } score_item_t;

    // One outgoing ranked entry.
    typedef struct packed {
        logic [RANK_W-1:0]         rank;
        logic [INDEX_W-1:0]        class_index;
        logic signed [SCORE_W-1:0] top_score;
        logic                      last_of_run;
    } result_item_t;

endpackage

`default_nettype wire

>>> design/tkss_select.sv
// ---------------------------------------------------------------------------
// tkss_select
// Sorted top-K list: parallel compare against every kept entry, insert
// with shift, hand-off of the finished list at the end of a vector.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tkss_select #(
    parameter int TOP_K       = 5,
    parameter int MAX_CLASSES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic signed [tkss_pkg::SCORE_W-1:0] score,
    input  logic                                last_score,
    output logic                                load,
    output logic [$clog2(TOP_K+1)-1:0]          count,
    output logic signed [tkss_pkg::SCORE_W-1:0] list_score [TOP_K],
    output logic [$clog2(MAX_CLASSES)-1:0]      list_index [TOP_K]
);

    localparam int SW    = tkss_pkg::SCORE_W;
    localparam int CNT_W = $clog2(TOP_K + 1);
    localparam int IDX_W = $clog2(MAX_CLASSES);

    logic signed [SW-1:0] sc_reg [TOP_K];
    logic [IDX_W-1:0]     ix_reg [TOP_K];
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic [IDX_W-1:0]     next_index_reg;
    logic [IDX_W-1:0]     next_index_next;
    logic [TOP_K-1:0]     ge;
    logic [TOP_K-1:0]     ge_prev;
    logic                 order_ok;

    // Kept entries that stay ahead of the new score (a prefix, list is sorted)
    always_comb
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            ge[i] = (CNT_W'(i) < fill_reg) && (sc_reg[i] >= score);
        end
        ge_prev[0] = 1'b0;
        for (int i = 1; i < TOP_K; i++)
        begin
            ge_prev[i] = ge[i-1];
        end
    end

    // Keep, insert here, or shift down by one
    always_comb
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            list_score[i] = sc_reg[i];
            list_index[i] = ix_reg[i];
            if (!ge[i] && (i == 0 || ge_prev[i]))
            begin
                list_score[i] = score;
                list_index[i] = next_index_reg;
            end
        end
        for (int i = 1; i < TOP_K; i++)
        begin
            if (!ge[i] && !ge_prev[i])
            begin
                list_score[i] = sc_reg[i-1];
                list_index[i] = ix_reg[i-1];
            end
        end
    end

    assign count = (fill_reg < CNT_W'(TOP_K)) ? fill_reg + CNT_W'(1) : fill_reg;
    assign load  = step && last_score;

    always_comb
    begin
        fill_next       = fill_reg;
        next_index_next = next_index_reg;
        if (step)
        begin
            if (last_score)
            begin
                fill_next       = '0;
                next_index_next = '0;
            end
            else
            begin
                fill_next = count;
                if (next_index_reg < IDX_W'(MAX_CLASSES - 1))
                begin
                    next_index_next = next_index_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            next_index_reg <= '0;
        end
        else
        begin
            fill_reg       <= fill_next;
            next_index_reg <= next_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < TOP_K; i++)
            begin
                sc_reg[i] <= list_score[i];
                ix_reg[i] <= list_index[i];
            end
        end
    end

    // Filled entries must stay in descending order
    always_comb
    begin
        order_ok = 1'b1;
        for (int i = 1; i < TOP_K; i++)
        begin
            if ((CNT_W'(i) < fill_reg) && (sc_reg[i-1] < sc_reg[i]))
            begin
                order_ok = 1'b0;
            end
        end
    end

    `TKSS_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(TOP_K), "fill count beyond TOP_K")
    `TKSS_ASSERT_ALWAYS(a_sorted, order_ok, "kept list out of order")
    `TKSS_ASSERT_IMPLIES(a_load_count, load, count != '0, "hand-off of an empty list")

endmodule

`default_nettype wire

>>> design/tkss_emit.sv
// ---------------------------------------------------------------------------
// tkss_emit
// Result buffer: holds a finished list and drains it one ranked entry per
// transaction from rank 0 down, flagging the final entry.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tkss_emit #(
    parameter int TOP_K       = 5,
    parameter int MAX_CLASSES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [$clog2(TOP_K+1)-1:0]          count,
    input  logic signed [tkss_pkg::SCORE_W-1:0] list_score [TOP_K],
    input  logic [$clog2(MAX_CLASSES)-1:0]      list_index [TOP_K],
    output logic                                free,
    output logic                                result_valid,
    input  logic                                result_stall,
    output tkss_pkg::result_item_t              result_item
);

    localparam int SW      = tkss_pkg::SCORE_W;
    localparam int CNT_W   = $clog2(TOP_K + 1);
    localparam int IDX_W   = $clog2(MAX_CLASSES);
    localparam int RANK_FW = tkss_pkg::RANK_W;
    localparam int INDX_FW = tkss_pkg::INDEX_W;

    logic signed [SW-1:0] em_sc_reg [TOP_K];
    logic [IDX_W-1:0]     em_ix_reg [TOP_K];
    logic [CNT_W-1:0]     left_reg;
    logic [CNT_W-1:0]     left_next;
    logic [CNT_W-1:0]     rank_reg;
    logic [CNT_W-1:0]     rank_next;
    logic                 take;

    assign result_valid = (left_reg != '0);
    assign take         = result_valid && !result_stall;
    assign free         = (left_reg == '0) || ((left_reg == CNT_W'(1)) && !result_stall);

    always_comb
    begin
        left_next = left_reg;
        rank_next = rank_reg;
        if (load)
        begin
            left_next = count;
            rank_next = '0;
        end
        else if (take)
        begin
            left_next = left_reg - CNT_W'(1);
            rank_next = rank_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            rank_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
            rank_reg <= rank_next;
        end
    end

    // Load a whole list, or advance the queue by one entry on each take
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < TOP_K; i++)
            begin
                em_sc_reg[i] <= list_score[i];
                em_ix_reg[i] <= list_index[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < TOP_K - 1; i++)
            begin
                em_sc_reg[i] <= em_sc_reg[i+1];
                em_ix_reg[i] <= em_ix_reg[i+1];
            end
        end
    end

    always_comb
    begin
        result_item.rank        = RANK_FW'(rank_reg);
        result_item.class_index = INDX_FW'(em_ix_reg[0]);
        result_item.top_score   = em_sc_reg[0];
        result_item.last_of_run = (left_reg == CNT_W'(1));
    end

    `TKSS_ASSERT_IMPLIES(a_load_free, load, free, "list loaded over pending results")
    `TKSS_ASSERT_NEXT(a_load_left, load, left_reg == $past(count), "loaded count lost")
    `TKSS_ASSERT_ALWAYS(a_left_bound, left_reg <= CNT_W'(TOP_K), "pending count beyond TOP_K")

endmodule

`default_nettype wire

>>> design/top_k_score_selector_core.sv
// Flow: a score is registered on acceptance and inserted into the list when it advances;
// the edge inserting a last score also loads the finished vector into the result buffer,
// so rank 0 is offered right after it.
// Throughput: one score per cycle; the buffer yields one result per cycle when not stalled.
// The input stalls only when a last score waits on a buffer still draining a prior vector.
// Reset (rst_n, asynchronous, active low) clears the handshake state, fill count and index.
// ---------------------------------------------------------------------------
// top_k_score_selector_core
// Streams class scores, keeps the TOP_K highest in descending order with their
// indices, and emits the ranked list at the end of every vector.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module top_k_score_selector_core #(
    parameter int TOP_K       = 5,
    parameter int MAX_CLASSES = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   score_valid,
    output logic                   score_stall,
    input  tkss_pkg::score_item_t  score_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tkss_pkg::result_item_t result_item
);

    localparam int SW    = tkss_pkg::SCORE_W;
    localparam int CNT_W = $clog2(TOP_K + 1);
    localparam int IDX_W = $clog2(MAX_CLASSES);

    // Input register: one score transaction waiting to be inserted
    logic                  ir_valid_reg;
    logic                  ir_valid_next;
    tkss_pkg::score_item_t ir_item_reg;

    logic                  accept;
    logic                  advance;
    logic                  emit_free;

    // Hand-off between the list and the result buffer
    logic                  load;
    logic [CNT_W-1:0]      count;
    logic signed [SW-1:0]  list_score [TOP_K];
    logic [IDX_W-1:0]      list_index [TOP_K];

    // Advance the held score into the list every cycle; a last score also
    // needs the result buffer free (empty, or handing out its final entry now).
    assign advance     = ir_valid_reg && (!ir_item_reg.last_score || emit_free);
    assign score_stall = ir_valid_reg && !advance;
    assign accept      = score_valid && !score_stall;

    always_comb
    begin
        ir_valid_next = ir_valid_reg;
        if (accept)
        begin
            ir_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ir_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
        end
        else
        begin
            ir_valid_reg <= ir_valid_next;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ir_item_reg <= score_item;
        end
    end

    // Sorted list: compare against all kept entries, insert, hand off on last
    tkss_select #(
        .TOP_K       (TOP_K),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .score      (ir_item_reg.score),
        .last_score (ir_item_reg.last_score),
        .load       (load),
        .count      (count),
        .list_score (list_score),
        .list_index (list_index)
    );

    // Result buffer: drain the finished list one ranked entry per transaction
    tkss_emit #(
        .TOP_K       (TOP_K),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .count        (count),
        .list_score   (list_score),
        .list_index   (list_index),
        .free         (emit_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    `TKSS_ASSERT_IMPLIES(a_stall_cause, score_stall, ir_valid_reg && ir_item_reg.last_score,
        "input stalled without a waiting last score")
    `TKSS_ASSERT_IMPLIES(a_stall_busy, score_stall, result_valid,
        "input stalled while the result buffer is empty")
    `TKSS_ASSERT_NEXT(a_stall_hold, score_stall, ir_valid_reg,
        "held score dropped during a stall")

endmodule

`default_nettype wire
